>>> rtl/core/darm_pkg.sv
package darm_pkg;

  // Size of the rule table and the widths that follow from it.
  localparam int unsigned MAX_RULES  = 64;
  localparam int unsigned RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned RULE_CNT_W = $clog2(MAX_RULES + 1);

  localparam int unsigned NUM_W  = 32;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned ACC_W  = 3;

  // Device type codes.
  localparam logic [TYPE_W-1:0] DEV_ANY     = 2'd0;
  localparam logic [TYPE_W-1:0] DEV_INVALID = 2'd3;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TYPE = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [TYPE_W-1:0] dev_type;
    logic [ACC_W-1:0]  access_bits;
    logic [NUM_W-1:0]  major_number;
    logic              major_wild;
    logic [NUM_W-1:0]  minor_number;
    logic              minor_wild;
    logic              rule_allow;
  } in_item_t;

  typedef struct packed {
    logic    granted;
    logic    hit_rule;
    status_e status;
  } out_item_t;

  // One stored rule, as one word of the rule memory.
  typedef struct packed {
    logic              allow;
    logic [ACC_W-1:0]  mask;
    logic [TYPE_W-1:0] dev_type;
    logic              major_wild;
    logic [NUM_W-1:0]  major;
    logic              minor_wild;
    logic [NUM_W-1:0]  minor;
  } rule_t;

  typedef struct packed {
    logic                  en;
    logic [RULE_IDX_W-1:0] addr;
    rule_t                 data;
  } rule_wr_t;

  typedef struct packed {
    logic                  en;
    logic [RULE_IDX_W-1:0] addr;
  } rule_rd_t;

  // True when a stored rule decides the given query.
  function automatic logic rule_match(rule_t r, in_item_t q);
    logic type_ok;
    logic acc_ok;
    logic maj_ok;
    logic min_ok;
    type_ok = (r.dev_type == DEV_ANY) || (r.dev_type == q.dev_type);
    acc_ok  = (q.access_bits & ~r.mask) == '0;
    maj_ok  = r.major_wild || (r.major == q.major_number);
    min_ok  = r.minor_wild || (r.minor == q.minor_number);
    return type_ok && acc_ok && maj_ok && min_ok;
  endfunction

endpackage

>>> rtl/core/darm_rule_ram.sv
module darm_rule_ram
  import darm_pkg::*;
(
  input  logic     clk_i,
  input  rule_wr_t wr_i,
  input  rule_rd_t rd_i,
  output rule_t    rd_data_o
);

  rule_t mem [MAX_RULES];
  rule_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/darm_scan_ctrl.sv
module darm_scan_ctrl
  import darm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      list_mode_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  output rule_wr_t  wr_o,
  output rule_rd_t  rd_o,
  input  rule_t     rd_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [RULE_CNT_W-1:0] count_q, count_d;
  logic [RULE_CNT_W-1:0] issue_q, issue_d;
  logic                  pend_q, pend_d;
  in_item_t              qry_q, qry_d;
  out_item_t             res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    qry_d       = qry_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_o        = '0;
    rd_o        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_APPEND) begin
            res_d = '{granted: 1'b0, hit_rule: 1'b0, status: STATUS_OK};
            if (in_data_i.dev_type == DEV_INVALID) begin
              res_d.status = STATUS_BAD_TYPE;
            end else if (count_q == RULE_CNT_W'(MAX_RULES)) begin
              res_d.status = STATUS_FULL;
            end else begin
              wr_o.en              = 1'b1;
              wr_o.addr            = count_q[RULE_IDX_W-1:0];
              wr_o.data.allow      = in_data_i.rule_allow;
              wr_o.data.mask       = in_data_i.access_bits;
              wr_o.data.dev_type   = in_data_i.dev_type;
              wr_o.data.major_wild = in_data_i.major_wild;
              wr_o.data.major      = in_data_i.major_number;
              wr_o.data.minor_wild = in_data_i.minor_wild;
              wr_o.data.minor      = in_data_i.minor_number;
              count_d              = RULE_CNT_W'(count_q + 1'b1);
            end
            state_d = S_DONE;
          end else begin
            qry_d   = in_data_i;
            issue_d = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Reads run one entry ahead of the compare.
        pend_d = 1'b0;
        if (issue_q < count_q) begin
          rd_o.en   = 1'b1;
          rd_o.addr = issue_q[RULE_IDX_W-1:0];
          issue_d   = RULE_CNT_W'(issue_q + 1'b1);
          pend_d    = 1'b1;
        end
        if (pend_q && rule_match(rd_data_i, qry_q)) begin
          res_d   = '{granted: rd_data_i.allow, hit_rule: 1'b1, status: STATUS_OK};
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (!pend_q && (issue_q == count_q)) begin
          res_d   = '{granted: list_mode_i, hit_rule: 1'b0, status: STATUS_OK};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      qry_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      qry_q       <= qry_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RULE_CNT_W'(MAX_RULES))
    else $error("rule count beyond table size");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= count_q)
    else $error("scan index beyond stored rules");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.en |-> (state_q == S_SCAN) && !wr_o.en)
    else $error("rule read outside a scan");

  a_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == S_IDLE) && (count_d == RULE_CNT_W'(count_q + 1'b1)))
    else $error("rule write without count update");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (!out_valid_q || !out_stall_i) |=> out_valid_q)
    else $error("finished result not presented");

endmodule

>>> rtl/core/device_access_rule_matcher.sv
// First-match device access filter.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries two kinds of
// item. An append item stores one rule at the end of the rule table; a rule of
// invalid type or an append to a full table is dropped and flagged in status.
// A query item scans the stored rules in append order and the first matching
// rule decides; with no match the list_mode register gives the default
// (0 deny, 1 allow). Every item gives one result item on the output channel
// (out_valid_o, out_stall_i, out_data_o).
// One item is worked on at a time. An append is decided as it is accepted, and
// its result then enters the output register. A query reads one rule per cycle
// and compares it in the cycle after the read; the first match ends the scan,
// else it ends once every stored rule is compared (an empty table ends it with
// no read). The block takes input again once the result enters the output
// register. While the receiver stalls, the output register holds its result
// and the next item is still taken; its result waits in the block until the
// register frees. Reset empties the rule table (the count returns to zero; the
// memory is not cleared since only entries below the count are read) and sets
// list_mode to 0. cfg_we_i and cfg_wdata_i write list_mode; the user must write
// it only while the block is idle, as the block itself does not enforce this.
module device_access_rule_matcher
  import darm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic     list_mode_q;
  rule_wr_t rule_wr;
  rule_rd_t rule_rd;
  rule_t    rule_rd_data;

  // Default decision for queries that no rule decides.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      list_mode_q <= cfg_wdata_i;
    end
  end

  // Scan sequencer: rule count, append writes, query reads and compare.
  darm_scan_ctrl u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .list_mode_i (list_mode_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .wr_o        (rule_wr),
    .rd_o        (rule_rd),
    .rd_data_i   (rule_rd_data)
  );

  // Rule table: one write and one registered read per cycle.
  darm_rule_ram u_rule_ram (
    .clk_i     (clk_i),
    .wr_i      (rule_wr),
    .rd_i      (rule_rd),
    .rd_data_o (rule_rd_data)
  );

endmodule
